FILE: rtl/mqts_pkg.sv
// ----------------------------------------------------------------------------
// mqts_pkg
// Shared types and codes for the mailbox queue with timer slot.
// ----------------------------------------------------------------------------
package mqts_pkg;

  // Request modes
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

  localparam logic [31:0] TIMER_CODE_RESET = 32'h0000_0000;

  // One stored message
  typedef struct packed {
    logic [31:0] header;
    logic [31:0] sender;
    logic [63:0] payload;
  } entry_t;

  // Per-cycle command broadcast to every queue cell
  typedef struct packed {
    logic load;   // write the new message into the cell at the count
    logic shift;  // cells at or above the removal index take their neighbor
  } cell_ctrl_t;

endpackage

FILE: rtl/mqts_cell.sv
// ----------------------------------------------------------------------------
// mqts_cell
// One queue slot: holds a message, takes its upper neighbor on a removal.
// ----------------------------------------------------------------------------
module mqts_cell #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX         = 0,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  mqts_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  logic [CW-1:0]       rm_idx_i,
  input  logic [CW-1:0]       rd_idx_i,
  input  mqts_pkg::entry_t    new_entry_i,
  input  mqts_pkg::entry_t    next_entry_i,
  output mqts_pkg::entry_t    entry_o,
  output mqts_pkg::entry_t    rd_data_o
);
  import mqts_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift && (MY_IDX >= rm_idx_i)) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.load && (MY_IDX == count_i)) begin
      entry_d = new_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  // drive only when addressed, so the top can OR all cells together
  assign rd_data_o = (MY_IDX == rd_idx_i) ? entry_q : '0;

endmodule

FILE: rtl/mailbox_queue_with_timer_slot.sv
// ----------------------------------------------------------------------------
// mailbox_queue_with_timer_slot
// Single-receiver mailbox: bounded message FIFO built from a row of cells,
// plus one coalescing timer slot.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  request  | start_i / busy_o       | mode_i, in_header_i, in_payload_i,
//           |                        | sender_id_i, peek_index_i, peek_remove_i
//  result   | done_o (1-cycle strobe)| status_o, out_header_o, out_sender_o,
//           |                        | out_payload_o, wakeup_o, pending_o,
//           |                        | queue_count_o
//  config   | cfg_we_i               | cfg_wdata_i (timer code)
//
// Each request is accepted on the edge where start_i is high, and its result
// shows on the next cycle with done_o. busy_o stays low, so a request may be
// issued every cycle; the row of cells shifts in parallel to close a gap, so
// removal at any position also completes on the edge that accepts it.
// Reset clears the count, the timer-slot valid bit, the pending flag and the
// timer code. The receiver cannot stall; each result is valid for one cycle.
// ----------------------------------------------------------------------------
module mailbox_queue_with_timer_slot #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] in_header_i,
  input  logic [63:0] in_payload_i,
  input  logic [31:0] sender_id_i,
  input  logic [4:0]  peek_index_i,
  input  logic        peek_remove_i,
  // result
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_header_o,
  output logic [31:0] out_sender_o,
  output logic [63:0] out_payload_o,
  output logic        wakeup_o,
  output logic        pending_o,
  output logic [4:0]  queue_count_o
);
  import mqts_pkg::*;

  // count must hold QUEUE_DEPTH itself
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  // common width for comparing the 5-bit peek index against the count
  localparam int CMP_W = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [CW-1:0] count_q, count_d;
  logic          timer_valid_q, timer_valid_d;
  logic          pending_q, pending_d;
  logic [31:0]   timer_code_q;
  logic [31:0]   timer_sender_q, timer_sender_d;
  logic [63:0]   timer_payload_q, timer_payload_d;

  logic          accept;
  assign busy_o = 1'b0;
  assign accept = start_i;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  cell_ctrl_t    ctrl, cell_ctrl;
  logic [CW-1:0] rm_idx, rd_idx;
  entry_t        new_entry;
  entry_t        cell_entry [QUEUE_DEPTH];
  entry_t        cell_rd    [QUEUE_DEPTH];
  entry_t        rd_entry;

  assign new_entry.header  = in_header_i;
  assign new_entry.sender  = sender_id_i;
  assign new_entry.payload = in_payload_i;

  // only move cells on an accepted request
  assign cell_ctrl.load  = ctrl.load  & accept;
  assign cell_ctrl.shift = ctrl.shift & accept;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t next_entry;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      // top cell keeps its stale contents on a shift; it is no longer occupied
      assign next_entry = cell_entry[g];
    end else begin : g_mid
      assign next_entry = cell_entry[g+1];
    end

    mqts_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (g),
      .CW          (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .count_i      (count_q),
      .rm_idx_i     (rm_idx),
      .rd_idx_i     (rd_idx),
      .new_entry_i  (new_entry),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[g]),
      .rd_data_o    (cell_rd[g])
    );
  end

  // gather the addressed cell; all others drive zero
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rd_entry = rd_entry | cell_rd[i];
    end
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] pidx_w, count_w, count_next_w;
  logic [1:0]       status_d;
  entry_t           out_d;
  logic             wake_d;

  assign pidx_w  = CMP_W'(peek_index_i);
  assign count_w = CMP_W'(count_q);

  // read the head on a receive, the peek index on a peek; an index past the
  // count is truncated here but its read data is never used
  assign rd_idx = (mode_i == MODE_PEEK) ? CW'(pidx_w) : '0;

  always_comb begin
    count_d         = count_q;
    timer_valid_d   = timer_valid_q;
    timer_sender_d  = timer_sender_q;
    timer_payload_d = timer_payload_q;
    pending_d       = pending_q;
    status_d        = STATUS_OK;
    out_d           = '0;
    wake_d          = 1'b0;
    ctrl            = '0;
    rm_idx          = '0;

    case (mode_i)
      MODE_SEND: begin
        if (in_header_i == timer_code_q) begin
          // coalesce: a second timer message is dropped but still accepted
          if (!timer_valid_q) begin
            timer_valid_d   = 1'b1;
            timer_sender_d  = sender_id_i;
            timer_payload_d = in_payload_i;
          end
          pending_d = 1'b1;
          wake_d    = 1'b1;
        end else if (count_q == FULL_COUNT) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          ctrl.load = 1'b1;
          count_d   = count_q + CW'(1);
          pending_d = 1'b1;
          wake_d    = 1'b1;
        end
      end
      MODE_RECV: begin
        if (count_q != '0) begin
          out_d      = rd_entry;
          ctrl.shift = 1'b1;
          count_d    = count_q - CW'(1);
          pending_d  = 1'b0;
        end else if (timer_valid_q) begin
          out_d.header  = timer_code_q;
          out_d.sender  = timer_sender_q;
          out_d.payload = timer_payload_q;
          timer_valid_d = 1'b0;
          pending_d     = 1'b0;
        end else begin
          status_d = STATUS_NOT_FOUND;
        end
      end
      MODE_PEEK: begin
        if ((pidx_w == count_w) && timer_valid_q) begin
          // timer slot sits just past the last queued message
          out_d.header  = timer_code_q;
          out_d.sender  = timer_sender_q;
          out_d.payload = timer_payload_q;
          if (peek_remove_i) begin
            timer_valid_d = 1'b0;
          end
          pending_d = 1'b0;
        end else if (pidx_w >= count_w) begin
          status_d = STATUS_BAD_INDEX;
        end else begin
          // index is below the count here, so it fits the cell index width
          out_d = rd_entry;
          if (peek_remove_i) begin
            ctrl.shift = 1'b1;
            rm_idx     = CW'(pidx_w);
            count_d    = count_q - CW'(1);
          end
          pending_d = 1'b0;
        end
      end
      default: begin
        // unused mode: leave state alone, report ok with empty fields
      end
    endcase
  end

  assign count_next_w = CMP_W'(count_d);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      timer_valid_q <= 1'b0;
      pending_q     <= 1'b0;
      timer_code_q  <= TIMER_CODE_RESET;
      done_o        <= 1'b0;
    end else begin
      done_o <= accept;
      if (cfg_we_i) begin
        timer_code_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q       <= count_d;
        timer_valid_q <= timer_valid_d;
        pending_q     <= pending_d;
      end
    end
  end

  // timer slot contents and result fields carry no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      timer_sender_q  <= timer_sender_d;
      timer_payload_q <= timer_payload_d;
      status_o        <= status_d;
      out_header_o    <= out_d.header;
      out_sender_o    <= out_d.sender;
      out_payload_o   <= out_d.payload;
      wakeup_o        <= wake_d;
      pending_o       <= pending_d;
      queue_count_o   <= count_next_w[4:0];
    end
  end

endmodule

FILE: tb/mailbox_queue_with_timer_slot_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mailbox_queue_with_timer_slot_test
// Drives send, receive and peek requests into the mailbox through a bursty
// driver, predicts each reply in a local copy of the message queue and timer
// slot, and compares every reply field by field as the monitor sees it.
// ----------------------------------------------------------------------------
module mailbox_queue_with_timer_slot_test;
  import mqts_pkg::*;

  localparam int         QUEUE_DEPTH = 16;
  localparam int         QUIET_LIMIT = 1000;  // cycles with no request and no reply
  localparam int         PHASE_SIZE  = 330;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] header;
    logic [63:0] payload;
    logic [31:0] sender;
    logic [4:0]  pidx;
    logic        prem;
  } mbox_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] header;
    logic [31:0] sender;
    logic [63:0] payload;
    logic        wakeup;
    logic        pending;
    logic [4:0]  count;
  } mbox_reply_t;

  // DUT ports; every input starts at a known value
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        start_i       = 1'b0;
  logic [1:0]  mode_i        = '0;
  logic [31:0] in_header_i   = '0;
  logic [63:0] in_payload_i  = '0;
  logic [31:0] sender_id_i   = '0;
  logic [4:0]  peek_index_i  = '0;
  logic        peek_remove_i = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] out_header_o;
  logic [31:0] out_sender_o;
  logic [63:0] out_payload_o;
  logic        wakeup_o;
  logic        pending_o;
  logic [4:0]  queue_count_o;

  // Local copy of the mailbox state
  logic [31:0] code_now     = TIMER_CODE_RESET;
  entry_t      held [QUEUE_DEPTH];
  int          fill         = 0;
  logic        slot_full    = 1'b0;
  logic [31:0] slot_sender  = '0;
  logic [63:0] slot_payload = '0;
  logic        flag_pending = 1'b0;

  // Requests waiting for the driver, and replies owed by the block
  mbox_req_t   queued_requests [$];
  mbox_reply_t due_replies [$];
  mbox_req_t   cur_req;

  int mismatches   = 0;
  int quiet_cycles = 0;
  int gap_max      = 0;
  int burst_left   = 0;
  int idle_left    = 0;

  mailbox_queue_with_timer_slot #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .in_header_i   (in_header_i),
    .in_payload_i  (in_payload_i),
    .sender_id_i   (sender_id_i),
    .peek_index_i  (peek_index_i),
    .peek_remove_i (peek_remove_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_header_o  (out_header_o),
    .out_sender_o  (out_sender_o),
    .out_payload_o (out_payload_o),
    .wakeup_o      (wakeup_o),
    .pending_o     (pending_o),
    .queue_count_o (queue_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Mailbox behavior
  // --------------------------------------------------------------------------

  // Drop the entry at idx and shift the younger ones down by one.
  function automatic void close_gap(input int idx);
    for (int i = idx; i + 1 < fill; i++) held[i] = held[i + 1];
    fill--;
  endfunction

  // Advance the local mailbox by one request and return the reply it owes.
  function automatic mbox_reply_t apply_request(input mbox_req_t r);
    mbox_reply_t rep;
    int          idx;
    rep = '0;
    idx = int'(r.pidx);
    case (r.mode)
      MODE_SEND: begin
        if (r.header == code_now) begin
          // Coalesce timer messages: a second one while the slot is full is
          // discarded, yet still counts as delivered.
          if (!slot_full) begin
            slot_full    = 1'b1;
            slot_sender  = r.sender;
            slot_payload = r.payload;
          end
          flag_pending = 1'b1;
          rep.wakeup   = 1'b1;
        end else if (fill >= QUEUE_DEPTH) begin
          rep.status = STATUS_OVERFLOW;
        end else begin
          held[fill].header  = r.header;
          held[fill].sender  = r.sender;
          held[fill].payload = r.payload;
          fill++;
          flag_pending = 1'b1;
          rep.wakeup   = 1'b1;
        end
      end
      MODE_RECV: begin
        if (fill > 0) begin
          rep.header  = held[0].header;
          rep.sender  = held[0].sender;
          rep.payload = held[0].payload;
          close_gap(0);
          flag_pending = 1'b0;
        end else if (slot_full) begin
          // The slot keeps no header; report the current timer code.
          rep.header   = code_now;
          rep.sender   = slot_sender;
          rep.payload  = slot_payload;
          slot_full    = 1'b0;
          flag_pending = 1'b0;
        end else begin
          rep.status = STATUS_NOT_FOUND;
        end
      end
      MODE_PEEK: begin
        if (idx == fill && slot_full) begin
          rep.header  = code_now;
          rep.sender  = slot_sender;
          rep.payload = slot_payload;
          if (r.prem) slot_full = 1'b0;
          flag_pending = 1'b0;
        end else if (idx >= fill) begin
          rep.status = STATUS_BAD_INDEX;
        end else begin
          rep.header  = held[idx].header;
          rep.sender  = held[idx].sender;
          rep.payload = held[idx].payload;
          if (r.prem) close_gap(idx);
          flag_pending = 1'b0;
        end
      end
      default: ;  // unused mode leaves the mailbox alone
    endcase
    rep.pending = flag_pending;
    rep.count   = fill[4:0];
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_request(input logic [1:0] mode, input logic [31:0] header,
                                       input logic [63:0] payload,
                                       input logic [31:0] sender,
                                       input logic [4:0] pidx, input logic prem);
    mbox_req_t r;
    r.mode    = mode;
    r.header  = header;
    r.payload = payload;
    r.sender  = sender;
    r.pidx    = pidx;
    r.prem    = prem;
    queued_requests.push_back(r);
  endfunction

  // Build one random request under the timer code in effect. send_pct biases
  // the mix toward filling or draining the queue.
  function automatic mbox_req_t random_request(input int send_pct);
    mbox_req_t r;
    int        roll;
    roll      = $urandom_range(0, 99);
    r.payload = {$urandom, $urandom};
    r.sender  = $urandom;
    r.prem    = 1'($urandom_range(0, 1));
    if (roll < send_pct) r.mode = MODE_SEND;
    else if (roll < send_pct + (95 - send_pct) / 2) r.mode = MODE_RECV;
    else if (roll < 95) r.mode = MODE_PEEK;
    else r.mode = MODE_UNUSED;
    // Mostly indexes near the live range, sometimes anywhere
    r.pidx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, QUEUE_DEPTH + 1));
    case ($urandom_range(0, 15))
      0, 1, 2: r.header = code_now;
      3:       r.header = '0;
      4:       r.header = '1;
      default: r.header = $urandom;
    endcase
    // Keep about a third of the headers that match the timer code; turn the rest into ordinary messages
    if (r.header == code_now && roll % 3 != 0) r.header = ~r.header;
    return r;
  endfunction

  // Hold until every request is out and every reply is back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || start_i || due_replies.size() != 0);
  endtask

  // Write the timer code while the block is idle.
  task automatic write_timer_code(input logic [31:0] code);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    code_now = code;
  endtask

  // --------------------------------------------------------------------------
  // Driver: issue queued requests in bursts with random gaps between them.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic drive_next;
    drive_next = 1'b0;
    if (rst_ni) begin
      // The request on the ports is taken at this edge: predict its reply.
      if (start_i && !busy_o) due_replies.push_back(apply_request(cur_req));
      // Hold the request while the block is busy, otherwise advance.
      if (!start_i || !busy_o) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (queued_requests.size() > 0) begin
          cur_req    = queued_requests.pop_front();
          drive_next = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          if (burst_left == 0 && gap_max > 0) idle_left = $urandom_range(1, gap_max);
        end
        start_i <= drive_next;
        if (drive_next) begin
          mode_i        <= cur_req.mode;
          in_header_i   <= cur_req.header;
          in_payload_i  <= cur_req.payload;
          sender_id_i   <= cur_req.sender;
          peek_index_i  <= cur_req.pidx;
          peek_remove_i <= cur_req.prem;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each strobed reply must match the oldest owed reply.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mbox_reply_t want;
    if (rst_ni && done_o) begin
      if (due_replies.size() == 0) begin
        flag_mismatch("reply with no request outstanding");
      end else begin
        want = due_replies.pop_front();
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("out_header", 64'(out_header_o), 64'(want.header));
        check_field("out_sender", 64'(out_sender_o), 64'(want.sender));
        check_field("out_payload", out_payload_o, want.payload);
        check_field("wakeup", 64'(wakeup_o), 64'(want.wakeup));
        check_field("pending", 64'(pending_o), 64'(want.pending));
        check_field("queue_count", 64'(queue_count_o), 64'(want.count));
      end
    end
  end

  // Count cycles in which neither a request nor a reply moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run if traffic stalls for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("mailbox_queue_with_timer_slot_test: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] codes [5];
    int          send_pct;
    codes[0] = 32'hFFFF_FFFF;
    codes[1] = $urandom;
    codes[2] = 32'h0000_0001;
    codes[3] = $urandom;
    codes[4] = 32'h0000_0000;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset timer code (zero).
    gap_max = 2;
    push_request(MODE_RECV, '0, '0, '0, 5'd0, 1'b0);   // nothing anywhere
    push_request(MODE_PEEK, '0, '0, '0, 5'd0, 1'b0);   // empty: bad index
    push_request(MODE_SEND, 32'h0, '1, '1, 5'd0, 1'b0); // fill the timer slot
    push_request(MODE_SEND, 32'h0, 64'h5, 32'h7, 5'd0, 1'b0);  // coalesced away
    push_request(MODE_PEEK, '0, '0, '0, 5'd0, 1'b0);   // index = count: timer slot
    push_request(MODE_UNUSED, '1, '1, '1, 5'd31, 1'b1);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == 0) push_request(MODE_SEND, 32'hFFFF_FFFF, '0, '0, 5'd0, 1'b0);
      else push_request(MODE_SEND, $urandom | 32'h1, {$urandom, $urandom}, $urandom,
                        5'd0, 1'b0);
    end
    push_request(MODE_SEND, 32'h1234, '1, '1, 5'd0, 1'b0);      // queue full
    push_request(MODE_PEEK, '0, '0, '0, 5'd16, 1'b1);           // take the timer slot
    push_request(MODE_PEEK, '0, '0, '0, 5'd16, 1'b0);           // slot now empty
    push_request(MODE_SEND, 32'h0, 64'hA5A5, 32'h3C, 5'd0, 1'b0);  // slot refills
    push_request(MODE_PEEK, '0, '0, '0, 5'd17, 1'b0);           // past the slot
    push_request(MODE_PEEK, '0, '0, '0, 5'd31, 1'b0);
    push_request(MODE_PEEK, '0, '0, '0, 5'd7, 1'b1);            // remove mid-queue
    push_request(MODE_PEEK, '0, '0, '0, 5'd14, 1'b1);           // remove the tail
    push_request(MODE_RECV, '0, '0, '0, 5'd0, 1'b0);

    // Random phases, each under its own timer code. The first runs with no
    // idling; the others with random gaps. The send share moves every 40
    // requests so the queue swings between empty and full.
    for (int p = 0; p < 5; p++) begin
      write_timer_code(codes[p]);
      gap_max = (p == 0) ? 0 : $urandom_range(1, 8);
      send_pct = 45;
      for (int n = 0; n < PHASE_SIZE; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       send_pct = 25;
            1:       send_pct = 45;
            default: send_pct = 75;
          endcase
        end
        queued_requests.push_back(random_request(send_pct));
      end
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("mailbox_queue_with_timer_slot_test: PASS");
    end else begin
      $display("mailbox_queue_with_timer_slot_test: FAIL");
    end
    $finish;
  end

endmodule
